@@ design/spf_pkg.sv @@
// Shared constants, codes and controller/datapath link types for the shortest path block.
`default_nettype none
package spf_pkg;
  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned MAX_EDGES_DEF    = 256;
  localparam int unsigned WEIGHT_BITS_DEF  = 16;
  localparam int unsigned DIST_BITS_DEF    = 32;

  localparam int VTX_W    = 6;
  localparam int CMD_W    = 2;
  localparam int WEIGHT_W = 16;
  localparam int PRICE_W  = 32;
  localparam int CNT_W    = 7;
  localparam int PAR_W    = 7;
  localparam int STS_W    = 2;

  localparam logic [PAR_W-1:0] NONE_CODE = 7'd127;

  typedef enum logic [1:0] {CMD_CLEAR, CMD_ADD, CMD_COMPUTE, CMD_QUERY} cmd_t;
  typedef enum logic [1:0] {ST_OK, ST_FULL, ST_RANGE, ST_NOT_COMPUTED} status_t;
  typedef enum logic [1:0] {NS_DST, NS_SCAN, NS_WALK} nsel_t;
  typedef enum logic [3:0] {
    S_IDLE, S_VISIT, S_E_RD, S_E_CHK, S_N_CHK, S_SC_RD, S_SC_CMP, S_SC_END,
    S_DONE, S_W_PUSH, S_W_NEXT, S_K_RD, S_K_OUT
  } state_t;

  typedef struct packed {
    logic    edge_clear;
    logic    edge_add;
    logic    res_clear;
    logic    res_set;
    logic    out_load;
    logic    out_path;
    status_t out_status;
    logic    init;
    logic    set_visit;
    logic    e_rst;
    logic    e_rd;
    logic    n_rd;
    nsel_t   nsel;
    logic    relax;
    logic    scan_rst;
    logic    scan_cmp;
    logic    take_best;
    logic    q_start;
    logic    push;
    logic    walk_next;
    logic    k_init;
    logic    k_dec;
    logic    stk_rd;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic add_range_bad;
    logic add_full;
    logic res_valid;
    logic tgt_bad;
    logic out_free;
    logic e_end;
    logic edge_hit;
    logic scan_end;
    logic found;
    logic walk_more;
    logic k_zero;
  } dp_sts_t;
endpackage
`default_nettype wire

@@ design/spf_ifs.sv @@
// Valid/ready channel interfaces: input beat, result beat and configuration write.
`default_nettype none
interface spf_in_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            command;
  logic [5:0]            from_vertex;
  logic [5:0]            to_vertex;
  logic [15:0]           weight;
  logic [5:0]            target_vertex;
  modport source(output valid, command, from_vertex, to_vertex, weight, target_vertex,
                 input ready);
  modport sink(input valid, command, from_vertex, to_vertex, weight, target_vertex,
               output ready);
endinterface

interface spf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  path_vertex;
  logic [31:0] price;
  logic        last;
  modport source(output valid, status, path_vertex, price, last, input ready);
  modport sink(input valid, status, path_vertex, price, last, output ready);
endinterface

interface spf_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] vertex_count;
  modport source(output valid, vertex_count, input ready);
  modport sink(input valid, vertex_count, output ready);
endinterface
`default_nettype wire

@@ design/spf_datapath.sv @@
// Datapath: edge store, distance/parent memory, path stack, config and result register.
`default_nettype none
module spf_datapath #(
  parameter int unsigned MAX_VERTICES = spf_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MAX_EDGES    = spf_pkg::MAX_EDGES_DEF,
  parameter int unsigned WEIGHT_BITS  = spf_pkg::WEIGHT_BITS_DEF,
  parameter int unsigned DIST_BITS    = spf_pkg::DIST_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spf_pkg::dp_cmd_t              cmd,
  output spf_pkg::dp_sts_t              sts,
  input  logic [spf_pkg::CMD_W-1:0]     command_i,
  input  logic [spf_pkg::VTX_W-1:0]     from_i,
  input  logic [spf_pkg::VTX_W-1:0]     to_i,
  input  logic [spf_pkg::WEIGHT_W-1:0]  weight_i,
  input  logic [spf_pkg::VTX_W-1:0]     tgt_i,
  input  logic                          cfg_valid_i,
  input  logic [spf_pkg::CNT_W-1:0]     cfg_data_i,
  output logic                          cfg_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [spf_pkg::STS_W-1:0]     out_status_o,
  output logic [spf_pkg::VTX_W-1:0]     out_vertex_o,
  output logic [spf_pkg::PRICE_W-1:0]   out_price_o,
  output logic                          out_last_o
);
  import spf_pkg::*;

  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int LW  = $clog2(MAX_VERTICES + 1);
  localparam int SW  = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;
  localparam logic [DIST_BITS-1:0] UNREACHED = {DIST_BITS{1'b1}};
  localparam logic [CNT_W-1:0]     VMAX      = CNT_W'(MAX_VERTICES);

  logic [CNT_W-1:0]       vcount_r;
  logic                   res_valid_r;
  logic [ETW-1:0]         edge_total_r;
  logic [VTX_W-1:0]       e_src_mem [MAX_EDGES];
  logic [VTX_W-1:0]       e_dst_mem [MAX_EDGES];
  logic [WEIGHT_BITS-1:0] e_cost_mem [MAX_EDGES];
  logic [VTX_W-1:0]       e_src_r, e_dst_r;
  logic [WEIGHT_BITS-1:0] e_cost_r;
  logic [ETW-1:0]         e_idx_r;
  logic [VIW-1:0]         cur_r;
  logic [DIST_BITS-1:0]   cur_dist_r;
  logic [MAX_VERTICES-1:0] visited_r, reached_r;
  logic [DIST_BITS-1:0]   dist_mem [MAX_VERTICES];
  logic [PAR_W-1:0]       par_mem [MAX_VERTICES];
  logic [DIST_BITS-1:0]   n_dist_r;
  logic [PAR_W-1:0]       n_par_r;
  logic [LW-1:0]          scan_i_r;
  logic [DIST_BITS-1:0]   best_r;
  logic [VIW-1:0]         best_i_r;
  logic                   found_r;
  logic [PAR_W-1:0]       walk_v_r;
  logic [LW-1:0]          len_r;
  logic [VTX_W-1:0]       stk_mem [MAX_VERTICES];
  logic [VTX_W-1:0]       stk_q_r;
  logic [VIW-1:0]         k_r;
  logic [DIST_BITS-1:0]   price_r;
  logic                   out_valid_r;
  logic [STS_W-1:0]       out_status_r;
  logic [VTX_W-1:0]       out_vertex_r;
  logic [PRICE_W-1:0]     out_price_r;
  logic                   out_last_r;

  logic [31:0]            w_ext;
  logic [WEIGHT_BITS-1:0] cost_in;
  logic [CNT_W-1:0]       vcount_nxt;
  logic [VIW-1:0]         dst_idx, scan_idx, walk_idx, nrd_addr, nwr_addr;
  logic [SW-1:0]          relax_sum;
  logic [DIST_BITS-1:0]   relax_s, relax_old, scan_dist, walk_dist, nwr_dist;
  logic [PAR_W-1:0]       walk_par, nwr_par;
  logic                   relax_better, nwr_en, scan_hit;
  logic [LW-1:0]          len_m1;

  assign w_ext    = 32'(weight_i);
  assign cost_in  = w_ext[WEIGHT_BITS-1:0];
  assign dst_idx  = e_dst_r[VIW-1:0];
  assign scan_idx = scan_i_r[VIW-1:0];
  assign walk_idx = walk_v_r[VIW-1:0];
  assign len_m1   = len_r - LW'(1);

  always_comb begin
    priority if (cfg_data_i == '0) begin
      vcount_nxt = CNT_W'(1);
    end else if (cfg_data_i > VMAX) begin
      vcount_nxt = VMAX;
    end else begin
      vcount_nxt = cfg_data_i;
    end
  end

  // relaxation: saturate below the unreached code
  assign relax_sum    = SW'(cur_dist_r) + SW'(e_cost_r);
  assign relax_s      = (relax_sum >= SW'(UNREACHED)) ? (UNREACHED - DIST_BITS'(1))
                                                      : relax_sum[DIST_BITS-1:0];
  assign relax_old    = reached_r[dst_idx] ? n_dist_r : UNREACHED;
  assign relax_better = relax_s < relax_old;

  assign scan_dist = reached_r[scan_idx] ? n_dist_r : UNREACHED;
  assign scan_hit  = !visited_r[scan_idx] && (scan_dist < best_r);
  assign walk_dist = reached_r[walk_idx] ? n_dist_r : UNREACHED;
  assign walk_par  = reached_r[walk_idx] ? n_par_r : NONE_CODE;

  always_comb begin
    unique case (cmd.nsel)
      NS_DST:  nrd_addr = dst_idx;
      NS_SCAN: nrd_addr = scan_idx;
      NS_WALK: nrd_addr = walk_idx;
      default: nrd_addr = '0;
    endcase
  end

  assign nwr_en   = cmd.init || (cmd.relax && relax_better);
  assign nwr_addr = cmd.init ? '0 : dst_idx;
  assign nwr_dist = cmd.init ? '0 : relax_s;
  assign nwr_par  = cmd.init ? NONE_CODE : PAR_W'(cur_r);

  always_comb begin
    sts.cmd           = cmd_t'(command_i);
    sts.add_range_bad = ({1'b0, from_i} >= vcount_r) || ({1'b0, to_i} >= vcount_r);
    sts.add_full      = edge_total_r == ETW'(MAX_EDGES);
    sts.res_valid     = res_valid_r;
    sts.tgt_bad       = {1'b0, tgt_i} >= vcount_r;
    sts.out_free      = !out_valid_r || out_ready_i;
    sts.e_end         = e_idx_r == edge_total_r;
    sts.edge_hit      = (e_src_r == VTX_W'(cur_r)) && ({1'b0, e_dst_r} < vcount_r);
    sts.scan_end      = scan_i_r == LW'(vcount_r);
    sts.found         = found_r;
    sts.walk_more     = (walk_v_r < PAR_W'(MAX_VERTICES)) && (len_r < LW'(MAX_VERTICES));
    sts.k_zero        = k_r == '0;
  end

  // edge store
  always_ff @(posedge clk) begin
    if (cmd.edge_add) begin
      e_src_mem[edge_total_r[EIW-1:0]]  <= from_i;
      e_dst_mem[edge_total_r[EIW-1:0]]  <= to_i;
      e_cost_mem[edge_total_r[EIW-1:0]] <= cost_in;
    end
    if (cmd.e_rd) begin
      e_src_r  <= e_src_mem[e_idx_r[EIW-1:0]];
      e_dst_r  <= e_dst_mem[e_idx_r[EIW-1:0]];
      e_cost_r <= e_cost_mem[e_idx_r[EIW-1:0]];
    end
  end

  // distance and parent memory
  always_ff @(posedge clk) begin
    if (nwr_en) begin
      dist_mem[nwr_addr] <= nwr_dist;
      par_mem[nwr_addr]  <= nwr_par;
    end
    if (cmd.n_rd) begin
      n_dist_r <= dist_mem[nrd_addr];
      n_par_r  <= par_mem[nrd_addr];
    end
  end

  // path stack
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stk_mem[len_r[VIW-1:0]] <= walk_v_r[VTX_W-1:0];
    end
    if (cmd.stk_rd) begin
      stk_q_r <= stk_mem[k_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r     <= VMAX;
      res_valid_r  <= 1'b0;
      edge_total_r <= '0;
      visited_r    <= '0;
      reached_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        vcount_r <= vcount_nxt;
      end
      if (cfg_valid_i || cmd.res_clear) begin
        res_valid_r <= 1'b0;
      end else if (cmd.res_set) begin
        res_valid_r <= 1'b1;
      end
      if (cmd.edge_clear) begin
        edge_total_r <= '0;
      end else if (cmd.edge_add) begin
        edge_total_r <= edge_total_r + ETW'(1);
      end
      if (cmd.init) begin
        visited_r <= '0;
        reached_r <= MAX_VERTICES'(1);
      end else begin
        if (cmd.set_visit) begin
          visited_r[cur_r] <= 1'b1;
        end
        if (cmd.relax && relax_better) begin
          reached_r[dst_idx] <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      cur_r      <= '0;
      cur_dist_r <= '0;
    end else if (cmd.take_best) begin
      cur_r      <= best_i_r;
      cur_dist_r <= best_r;
    end
    if (cmd.e_rst) begin
      e_idx_r <= '0;
    end else if (cmd.e_rd) begin
      e_idx_r <= e_idx_r + ETW'(1);
    end
    if (cmd.scan_rst) begin
      scan_i_r <= '0;
      best_r   <= UNREACHED;
      found_r  <= 1'b0;
    end else if (cmd.scan_cmp) begin
      scan_i_r <= scan_i_r + LW'(1);
      if (scan_hit) begin
        best_r   <= scan_dist;
        best_i_r <= scan_idx;
        found_r  <= 1'b1;
      end
    end
    if (cmd.q_start) begin
      walk_v_r <= PAR_W'(tgt_i);
      len_r    <= '0;
    end else begin
      if (cmd.push) begin
        len_r <= len_r + LW'(1);
      end
      if (cmd.walk_next) begin
        walk_v_r <= walk_par;
        if (len_r == LW'(1)) begin
          price_r <= walk_dist;
        end
      end
    end
    if (cmd.k_init) begin
      k_r <= len_m1[VIW-1:0];
    end else if (cmd.k_dec) begin
      k_r <= k_r - VIW'(1);
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_path ? STS_W'(ST_OK) : STS_W'(cmd.out_status);
      out_vertex_r <= cmd.out_path ? stk_q_r : '0;
      out_price_r  <= cmd.out_path ? PRICE_W'(price_r) : '0;
      out_last_r   <= cmd.out_path ? (k_r == '0) : 1'b1;
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_r;
  assign out_status_o = out_status_r;
  assign out_vertex_o = out_vertex_r;
  assign out_price_o  = out_price_r;
  assign out_last_o   = out_last_r;

  a_edge_total: assert property (@(posedge clk) disable iff (!rst_n)
    edge_total_r <= ETW'(MAX_EDGES)) else $error("edge count beyond store");
  a_vcount: assert property (@(posedge clk) disable iff (!rst_n)
    (vcount_r != '0) && (vcount_r <= VMAX)) else $error("vertex count out of range");
  a_visit_reach: assert property (@(posedge clk) disable iff (!rst_n)
    (visited_r & ~reached_r) == '0) else $error("visited vertex not reached");
endmodule
`default_nettype wire

@@ design/spf_ctrl.sv @@
// Controller: sequences edge loads, the Dijkstra passes and the path walk and readout.
`default_nettype none
module spf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  spf_pkg::dp_sts_t sts,
  output spf_pkg::dp_cmd_t cmd
);
  import spf_pkg::*;

  state_t state_r, state_nxt;
  logic   take;

  assign take = (state_r == S_IDLE) && in_valid_i && sts.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          if (sts.cmd == CMD_COMPUTE) begin
            state_nxt = S_VISIT;
          end else if (sts.cmd == CMD_QUERY && sts.res_valid && !sts.tgt_bad) begin
            state_nxt = S_W_PUSH;
          end
        end
      end
      S_VISIT:  state_nxt = S_E_RD;
      S_E_RD:   state_nxt = sts.e_end ? S_SC_RD : S_E_CHK;
      S_E_CHK:  state_nxt = sts.edge_hit ? S_N_CHK : S_E_RD;
      S_N_CHK:  state_nxt = S_E_RD;
      S_SC_RD:  state_nxt = sts.scan_end ? S_SC_END : S_SC_CMP;
      S_SC_CMP: state_nxt = S_SC_RD;
      S_SC_END: state_nxt = sts.found ? S_VISIT : S_DONE;
      S_DONE:   state_nxt = sts.out_free ? S_IDLE : S_DONE;
      S_W_PUSH: state_nxt = sts.walk_more ? S_W_NEXT : S_K_RD;
      S_W_NEXT: state_nxt = S_W_PUSH;
      S_K_RD:   state_nxt = S_K_OUT;
      S_K_OUT: begin
        if (sts.out_free) begin
          state_nxt = sts.k_zero ? S_IDLE : S_K_RD;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_ready_o = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready_o = sts.out_free;
        if (take) begin
          unique case (sts.cmd)
            CMD_CLEAR: begin
              cmd.edge_clear = 1'b1;
              cmd.res_clear  = 1'b1;
              cmd.out_load   = 1'b1;
              cmd.out_status = ST_OK;
            end
            CMD_ADD: begin
              cmd.out_load = 1'b1;
              priority if (sts.add_range_bad) begin
                cmd.out_status = ST_RANGE;
              end else if (sts.add_full) begin
                cmd.out_status = ST_FULL;
              end else begin
                cmd.out_status = ST_OK;
                cmd.edge_add   = 1'b1;
                cmd.res_clear  = 1'b1;
              end
            end
            CMD_COMPUTE: cmd.init = 1'b1;
            CMD_QUERY: begin
              priority if (!sts.res_valid) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_NOT_COMPUTED;
              end else if (sts.tgt_bad) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_RANGE;
              end else begin
                cmd.q_start = 1'b1;
              end
            end
            default: cmd = '0;
          endcase
        end
      end
      S_VISIT: begin
        cmd.set_visit = 1'b1;
        cmd.e_rst     = 1'b1;
      end
      S_E_RD: begin
        if (sts.e_end) begin
          cmd.scan_rst = 1'b1;
        end else begin
          cmd.e_rd = 1'b1;
        end
      end
      S_E_CHK: begin
        cmd.nsel = NS_DST;
        cmd.n_rd = sts.edge_hit;
      end
      S_N_CHK: cmd.relax = 1'b1;
      S_SC_RD: begin
        cmd.nsel = NS_SCAN;
        cmd.n_rd = !sts.scan_end;
      end
      S_SC_CMP: cmd.scan_cmp = 1'b1;
      S_SC_END: begin
        cmd.take_best = sts.found;
        cmd.res_set   = !sts.found;
      end
      S_DONE: begin
        cmd.out_load   = sts.out_free;
        cmd.out_status = ST_OK;
      end
      S_W_PUSH: begin
        cmd.nsel   = NS_WALK;
        cmd.push   = sts.walk_more;
        cmd.n_rd   = sts.walk_more;
        cmd.k_init = !sts.walk_more;
      end
      S_W_NEXT: cmd.walk_next = 1'b1;
      S_K_RD:   cmd.stk_rd = 1'b1;
      S_K_OUT: begin
        cmd.out_load = sts.out_free;
        cmd.out_path = 1'b1;
        cmd.k_dec    = sts.out_free && !sts.k_zero;
      end
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

@@ design/shortest_path_from_source.sv @@
// Top level of the single-source shortest path engine (array Dijkstra from vertex 0).
// Channels: in_ch takes command beats (clear, add edge, compute, query); out_ch gives
// result beats with status, path vertex, price and a last flag; cfg_ch writes the
// vertex count and is always ready.
// Clear, add edge and query errors give one beat.
// Compute walks the stored graph: per chosen vertex it marks the vertex visited, reads
// every stored edge and relaxes each one that leaves the chosen vertex towards a vertex
// below N (N vertex count), then scans the N vertices for the nearest unvisited reached
// one; it gives one beat at the end.
// Query walks parents from the target and stacks each path vertex, then reads the path
// back one beat per stacked vertex; the last beat carries last = 1.
// Input is taken only between commands and while the result register is free or
// being drained; a stalled receiver holds the current beat and the sequencer.
// Reset (rst_n low, synchronous) empties the edge store, sets the vertex count to
// its maximum, marks results invalid and drops any pending beat. No clearing pass.
`default_nettype none
module shortest_path_from_source #(
  parameter int unsigned MAX_VERTICES = spf_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MAX_EDGES    = spf_pkg::MAX_EDGES_DEF,
  parameter int unsigned WEIGHT_BITS  = spf_pkg::WEIGHT_BITS_DEF,
  parameter int unsigned DIST_BITS    = spf_pkg::DIST_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  spf_in_if.sink    in_ch,
  spf_out_if.source out_ch,
  spf_cfg_if.sink   cfg_ch
);
  import spf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  spf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  spf_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS),
    .DIST_BITS    (DIST_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .command_i    (in_ch.command),
    .from_i       (in_ch.from_vertex),
    .to_i         (in_ch.to_vertex),
    .weight_i     (in_ch.weight),
    .tgt_i        (in_ch.target_vertex),
    .cfg_valid_i  (cfg_ch.valid),
    .cfg_data_i   (cfg_ch.vertex_count),
    .cfg_ready_o  (cfg_ch.ready),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_status_o (out_ch.status),
    .out_vertex_o (out_ch.path_vertex),
    .out_price_o  (out_ch.price),
    .out_last_o   (out_ch.last)
  );
endmodule
`default_nettype wire
